>>> src/ps2_mouse_packet_assembler_assert.svh
// assertion macros used by the checker file
`ifndef PS2_MOUSE_PACKET_ASSEMBLER_ASSERT_SVH
`define PS2_MOUSE_PACKET_ASSEMBLER_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define PMA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("pma assertion failed");

// next-cycle implication, disabled while reset is low
`define PMA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("pma assertion failed");

`endif

>>> src/pma_pkg.sv
// types, codes and result builders for the ps2 mouse packet assembler
package pma_pkg;

	localparam logic [1:0] KIND_DUMP = 2'd0;
	localparam logic [1:0] KIND_MOVE = 2'd1;
	localparam logic [1:0] KIND_ACK  = 2'd2;

	localparam logic [7:0] ACK_BYTE = 8'hFA;

	typedef struct packed {
		logic [1:0] kind;
		logic       group_host;
		logic [1:0] group_len;
		logic [7:0] first_byte;
		logic [7:0] second_byte;
		logic [7:0] third_byte;
		logic [2:0] buttons;
		logic [8:0] delta_x;
		logic [8:0] delta_y;
		logic       x_overflow;
		logic       y_overflow;
		logic       last;
	} result_t;

	function automatic result_t mk_dump(input logic host, input logic [1:0] len,
		input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2);
		result_t r;
		r             = '0;
		r.kind        = KIND_DUMP;
		r.group_host  = host;
		r.group_len   = len;
		r.first_byte  = b0;
		r.second_byte = b1;
		r.third_byte  = b2;
		return r;
	endfunction

	function automatic result_t mk_move(input logic [7:0] b0, input logic [7:0] b1,
		input logic [7:0] b2);
		result_t r;
		r             = '0;
		r.kind        = KIND_MOVE;
		r.group_host  = 1'b0;
		r.group_len   = 2'd3;
		r.first_byte  = b0;
		r.second_byte = b1;
		r.third_byte  = b2;
		r.buttons     = b0[2:0];
		r.delta_x     = {b0[4], b1};
		r.delta_y     = {b0[5], b2};
		r.x_overflow  = b0[6];
		r.y_overflow  = b0[7];
		return r;
	endfunction

	function automatic result_t mk_ack();
		result_t r;
		r      = '0;
		r.kind = KIND_ACK;
		return r;
	endfunction

endpackage

>>> src/ps2_mouse_packet_assembler.sv
// ps2 mouse packet assembler: groups ps2 bytes by direction and emits dump, movement and ack results
// A byte beat enters an input register and is decoded from it against the open group
// (up to two held bytes and their direction); the zero, one or two results it causes are written
// into a four-entry result queue that drives the output port, one result beat per cycle while
// out_stall is low. The input side keeps taking a byte every cycle while the queue has two free
// entries, so a byte that causes two results uses twice the output bandwidth of one that causes
// one; the single output port is what sets the sustained rate. No clearing pass is needed after
// reset.
module ps2_mouse_packet_assembler
	import pma_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        data_byte,
	input  logic              from_host,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        kind,
	output logic              group_host,
	output logic [1:0]        group_len,
	output logic [7:0]        first_byte,
	output logic [7:0]        second_byte,
	output logic [7:0]        third_byte,
	output logic [2:0]        buttons,
	output logic signed [8:0] delta_x,
	output logic signed [8:0] delta_y,
	output logic              x_overflow,
	output logic              y_overflow,
	output logic              last
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       host_s1;

	logic [1:0] held_count_q;
	logic [7:0] held_bytes_q [2];
	logic       held_dir_q;

	result_t    fifo_q [4];
	logic [1:0] wr_q;
	logic [1:0] rd_q;
	logic [2:0] fcnt_q;

	logic       in_accept;
	logic       commit;
	logic       pop;
	logic       flush;
	logic       is_ack;
	result_t    res0;
	result_t    res1;
	logic [1:0] nres;
	logic [1:0] nres_eff;
	logic [1:0] cnt_d;
	logic       dir_d;
	logic       store_en;
	logic [7:0] b0_open;
	logic [7:0] b1_open;
	result_t    head;

	assign commit    = valid_s1 & (fcnt_q <= 3'd2);
	assign in_stall  = valid_s1 & ~commit;
	assign in_accept = in_valid & ~in_stall;
	assign out_valid = (fcnt_q != 3'd0);
	assign pop       = out_valid & ~out_stall;
	assign nres_eff  = commit ? nres : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (commit) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			byte_s1 <= data_byte;
			host_s1 <= from_host;
		end
	end

	// decode one byte against the open group
	always_comb begin
		flush   = (held_count_q != 2'd0) && (host_s1 != held_dir_q);
		is_ack  = flush && (byte_s1 == ACK_BYTE) && !host_s1;
		b0_open = (held_count_q > 2'd0) ? held_bytes_q[0] : 8'd0;
		b1_open = (held_count_q > 2'd1) ? held_bytes_q[1] : 8'd0;
		res0     = '0;
		res1     = '0;
		nres     = 2'd0;
		cnt_d    = held_count_q;
		dir_d    = held_dir_q;
		store_en = 1'b0;
		if (flush) begin
			res0 = mk_dump(held_dir_q, held_count_q, b0_open, b1_open, 8'd0);
			if (is_ack) begin
				res1  = mk_ack();
				nres  = 2'd2;
				cnt_d = 2'd0;
				dir_d = 1'b0;
			end else begin
				nres     = 2'd1;
				cnt_d    = 2'd1;
				dir_d    = host_s1;
				store_en = 1'b1;
			end
		end else if (held_count_q < 2'd2) begin
			cnt_d    = held_count_q + 2'd1;
			dir_d    = host_s1;
			store_en = 1'b1;
		end else begin
			cnt_d = 2'd0;
			if (!held_dir_q) begin
				res0 = mk_move(held_bytes_q[0], held_bytes_q[1], byte_s1);
				res1 = mk_dump(1'b0, 2'd3, held_bytes_q[0], held_bytes_q[1], byte_s1);
				nres = 2'd2;
			end else begin
				res0 = mk_dump(1'b1, 2'd3, held_bytes_q[0], held_bytes_q[1], byte_s1);
				nres = 2'd1;
			end
		end
		res0.last = (nres == 2'd1);
		res1.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_count_q <= 2'd0;
			held_dir_q   <= 1'b0;
		end else if (commit) begin
			held_count_q <= cnt_d;
			held_dir_q   <= dir_d;
		end
	end

	// a flush restarts the group at slot zero
	always_ff @(posedge clk) begin
		if (commit && store_en) begin
			held_bytes_q[flush ? 1'b0 : held_count_q[0]] <= byte_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (nres_eff != 2'd0) begin
			fifo_q[wr_q] <= res0;
		end
		if (nres_eff == 2'd2) begin
			fifo_q[wr_q + 2'd1] <= res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= 2'd0;
			rd_q   <= 2'd0;
			fcnt_q <= 3'd0;
		end else begin
			wr_q   <= wr_q + nres_eff;
			rd_q   <= rd_q + {1'b0, pop};
			fcnt_q <= fcnt_q + {1'b0, nres_eff} - {2'b00, pop};
		end
	end

	assign head        = fifo_q[rd_q];
	assign kind        = head.kind;
	assign group_host  = head.group_host;
	assign group_len   = head.group_len;
	assign first_byte  = head.first_byte;
	assign second_byte = head.second_byte;
	assign third_byte  = head.third_byte;
	assign buttons     = head.buttons;
	assign delta_x     = $signed(head.delta_x);
	assign delta_y     = $signed(head.delta_y);
	assign x_overflow  = head.x_overflow;
	assign y_overflow  = head.y_overflow;
	assign last        = head.last;

endmodule

>>> src/pma_checker.sv
// port-level checker for the ps2 mouse packet assembler, bound to the top level
`include "ps2_mouse_packet_assembler_assert.svh"

module pma_checker
	import pma_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic [7:0]        data_byte,
	input logic              from_host,
	input logic              out_valid,
	input logic              out_stall,
	input logic [1:0]        kind,
	input logic              group_host,
	input logic [1:0]        group_len,
	input logic [7:0]        first_byte,
	input logic [7:0]        second_byte,
	input logic [7:0]        third_byte,
	input logic [2:0]        buttons,
	input logic signed [8:0] delta_x,
	input logic signed [8:0] delta_y,
	input logic              x_overflow,
	input logic              y_overflow,
	input logic              last
);

	// a stalled result beat holds
	`PMA_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(kind) && $stable(first_byte) && $stable(last))

	// ack beats carry no group and always end the byte's results
	`PMA_ASSERT_NOW(a_ack_shape, clk, arst_n, out_valid && kind == KIND_ACK,
		group_len == 2'd0 && !group_host && last && first_byte == 8'd0)

	// a movement beat is a full mouse group and is always followed by its dump
	`PMA_ASSERT_NOW(a_move_shape, clk, arst_n, out_valid && kind == KIND_MOVE,
		group_len == 2'd3 && !group_host && !last
		&& delta_x[7:0] == second_byte && delta_y[7:0] == third_byte
		&& buttons == first_byte[2:0])

	// dump beats never carry decoded movement and never describe an empty group
	`PMA_ASSERT_NOW(a_dump_shape, clk, arst_n, out_valid && kind == KIND_DUMP,
		group_len != 2'd0 && buttons == 3'd0 && !x_overflow && !y_overflow
		&& delta_x == 9'sd0 && delta_y == 9'sd0)

	// only the three defined kinds appear
	`PMA_ASSERT_NOW(a_kind_code, clk, arst_n, out_valid,
		kind == KIND_DUMP || kind == KIND_MOVE || kind == KIND_ACK)

endmodule

bind ps2_mouse_packet_assembler pma_checker u_pma_checker (.*);
